>>> rtl/gbns_pkg.sv
// Shared types and constants of the go-back-n sender window.
// Depends on nothing; every other file of the block but gbns_ram refers to it by scoped names.
`default_nettype none

package gbns_pkg;

	// input mode codes
	localparam logic [1:0] MODE_SEND = 2'd0;
	localparam logic [1:0] MODE_ACK  = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;
	localparam logic [1:0] MODE_NOP  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_WINDOW_SIZE   = 2'd0;
	localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd1;
	localparam logic [1:0] REG_FIRST_SEQ     = 2'd2;

	// configuration reset values
	localparam logic [6:0]  WINDOW_SIZE_RST   = 7'd10;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;
	localparam logic [31:0] FIRST_SEQ_RST     = 32'd0;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = 1;

	typedef enum logic [1:0] {
		OP_SEND,
		OP_ACK,
		OP_TICK
	} op_t;

	typedef enum logic [2:0] {
		KIND_TX    = 3'd0,
		KIND_RETX  = 3'd1,
		KIND_ACK   = 3'd2,
		KIND_IGN   = 3'd3,
		KIND_FULL  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACK_OUT,
		ST_BURST_RD,
		ST_BURST_OUT
	} state_t;

	// one classified command word
	typedef struct packed {
		op_t         op;
		logic [31:0] payload;
		logic [31:0] ack_seq;
		logic        intact;
	} item_t;

	// one result word
	typedef struct packed {
		kind_t       kind;
		logic [31:0] seq;
		logic [31:0] payload;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/gbns_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module gbns_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/gbns_front.sv
// Front end: accepts input words, classifies the mode and queues commands.
// Depends on gbns_pkg.
`default_nettype none

module gbns_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire logic [1:0]      mode,
	input  wire logic [31:0]     payload,
	input  wire logic [31:0]     ack_seq,
	input  wire logic            ack_intact,
	output logic                 q_vld,
	output gbns_pkg::item_t      q_item,
	input  wire logic            q_deq
);

	localparam int QD  = gbns_pkg::QUEUE_DEPTH;
	localparam int QAW = gbns_pkg::QUEUE_AW;

	gbns_pkg::item_t  ent_q [QD];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     cnt_q;
	gbns_pkg::item_t  cls;
	logic             keep;
	logic             accept;
	logic             store;

	assign full   = (cnt_q == (QAW+1)'(QD));
	assign q_vld  = (cnt_q != '0);
	assign q_item = ent_q[rd_ptr_q];
	assign accept = push && !full;
	assign store  = accept && keep;

	// classify the mode; drop the unused code
	always_comb begin
		cls.payload = payload;
		cls.ack_seq = ack_seq;
		cls.intact  = ack_intact;
		cls.op      = gbns_pkg::OP_SEND;
		keep        = 1'b1;
		unique case (mode)
			gbns_pkg::MODE_SEND: cls.op = gbns_pkg::OP_SEND;
			gbns_pkg::MODE_ACK:  cls.op = gbns_pkg::OP_ACK;
			gbns_pkg::MODE_TICK: cls.op = gbns_pkg::OP_TICK;
			gbns_pkg::MODE_NOP:  keep   = 1'b0;
			default:             keep   = 1'b0;
		endcase
	end

	// store the command word
	always_ff @(posedge clk) begin
		if (store) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (store) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QD-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_deq) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QD-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (store && !q_deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!store && q_deq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/gbns_back.sv
// Back end: window state, payload ring, ack retire, timer and resend bursts.
// Depends on gbns_pkg and gbns_ram.
`default_nettype none

module gbns_back #(
	parameter int RING_DEPTH    = 64,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              restart,
	input  wire logic [31:0]       restart_seq,
	input  wire logic [6:0]        window_size,
	input  wire logic [15:0]       timeout_ticks,
	input  wire logic              q_vld,
	input  wire gbns_pkg::item_t   q_item,
	output logic                   q_deq,
	output logic                   res_vld,
	output gbns_pkg::result_t      res,
	input  wire logic              res_pop
);

	localparam int SW = $clog2(RING_DEPTH);
	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam int WW = (CW > 7) ? CW : 7;
	localparam int PW = PAYLOAD_WIDTH;

	gbns_pkg::state_t   state_q, state_d;
	logic [31:0]        next_seq_q, base_seq_q, cur_seq_q;
	logic [SW-1:0]      next_slot_q, base_slot_q, rd_slot_q;
	logic [CW-1:0]      cnt_q, left_q;
	logic               run_q;
	logic [15:0]        elapsed_q;
	logic               out_vld_q;
	gbns_pkg::result_t  out_q, out_d;

	logic               out_free, out_load;
	logic               do_send, do_ack, do_inc, do_timeout, do_step;
	logic               ram_we, ram_re;
	logic [SW-1:0]      ram_raddr;
	logic [PW-1:0]      ram_rdata;
	logic [PW-1:0]      pay_w;
	logic [31:0]        pay32;
	logic [WW-1:0]      ws_ext, depth_w, win;
	logic               win_full, ack_hit;

	assign res_vld  = out_vld_q;
	assign res      = out_q;
	assign out_free = !out_vld_q || res_pop;

	// clamp the window to the ring
	assign ws_ext   = WW'(window_size);
	assign depth_w  = WW'(RING_DEPTH);
	assign win      = (ws_ext > depth_w) ? depth_w : ws_ext;
	assign win_full = (WW'(cnt_q) >= win);
	assign ack_hit  = q_item.intact && (cnt_q != '0) && (q_item.ack_seq == base_seq_q);
	assign pay_w    = PW'(q_item.payload);
	assign pay32    = 32'(pay_w);

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
		return (s == SW'(RING_DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	gbns_ram #(
		.WIDTH(PW),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (next_slot_q),
		.wdata (pay_w),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbns_pkg::ST_IDLE;
		end else if (restart) begin
			state_q <= gbns_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, command decode and result selection
	always_comb begin
		state_d    = state_q;
		q_deq      = 1'b0;
		out_load   = 1'b0;
		out_d      = '{kind: gbns_pkg::KIND_TX, seq: next_seq_q, payload: pay32, last: 1'b1};
		do_send    = 1'b0;
		do_ack     = 1'b0;
		do_inc     = 1'b0;
		do_timeout = 1'b0;
		do_step    = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = rd_slot_q;
		unique case (state_q)
			gbns_pkg::ST_IDLE: begin
				if (q_vld && out_free) begin
					q_deq = 1'b1;
					case (q_item.op)
						gbns_pkg::OP_SEND: begin
							out_load = 1'b1;
							if (win_full) begin
								out_d.kind = gbns_pkg::KIND_FULL;
							end else begin
								ram_we  = 1'b1;
								do_send = 1'b1;
							end
						end
						gbns_pkg::OP_ACK: begin
							if (ack_hit) begin
								do_ack    = 1'b1;
								ram_re    = 1'b1;
								ram_raddr = base_slot_q;
								state_d   = gbns_pkg::ST_ACK_OUT;
							end else begin
								out_load = 1'b1;
								out_d    = '{kind: gbns_pkg::KIND_IGN, seq: q_item.ack_seq,
									payload: 32'd0, last: 1'b1};
							end
						end
						gbns_pkg::OP_TICK: begin
							if (run_q) begin
								if (elapsed_q < timeout_ticks) begin
									do_inc = 1'b1;
								end else begin
									do_timeout = 1'b1;
									if (cnt_q != '0) begin
										state_d = gbns_pkg::ST_BURST_RD;
									end
								end
							end
						end
						default: ;
					endcase
				end
			end
			gbns_pkg::ST_ACK_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d    = '{kind: gbns_pkg::KIND_ACK, seq: cur_seq_q,
						payload: 32'(ram_rdata), last: 1'b1};
					state_d  = gbns_pkg::ST_IDLE;
				end
			end
			gbns_pkg::ST_BURST_RD: begin
				ram_re  = 1'b1;
				state_d = gbns_pkg::ST_BURST_OUT;
			end
			gbns_pkg::ST_BURST_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					do_step  = 1'b1;
					out_d    = '{kind: gbns_pkg::KIND_RETX, seq: cur_seq_q,
						payload: 32'(ram_rdata), last: (left_q == CW'(1))};
					state_d  = (left_q == CW'(1)) ? gbns_pkg::ST_IDLE
						: gbns_pkg::ST_BURST_RD;
				end
			end
			default: state_d = gbns_pkg::ST_IDLE;
		endcase
	end

	// window counters and timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_seq_q  <= gbns_pkg::FIRST_SEQ_RST;
			base_seq_q  <= gbns_pkg::FIRST_SEQ_RST;
			next_slot_q <= '0;
			base_slot_q <= '0;
			cnt_q       <= '0;
			run_q       <= 1'b0;
			elapsed_q   <= '0;
		end else if (restart) begin
			next_seq_q  <= restart_seq;
			base_seq_q  <= restart_seq;
			next_slot_q <= '0;
			base_slot_q <= '0;
			cnt_q       <= '0;
			run_q       <= 1'b0;
			elapsed_q   <= '0;
		end else begin
			if (do_send) begin
				next_seq_q  <= next_seq_q + 32'd1;
				next_slot_q <= slot_inc(next_slot_q);
				cnt_q       <= cnt_q + 1'b1;
				if (!run_q) begin
					run_q     <= 1'b1;
					elapsed_q <= '0;
				end
			end
			if (do_ack) begin
				base_seq_q  <= base_seq_q + 32'd1;
				base_slot_q <= slot_inc(base_slot_q);
				cnt_q       <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q     <= 1'b0;
					elapsed_q <= '0;
				end
			end
			if (do_inc) begin
				elapsed_q <= elapsed_q + 16'd1;
			end
			if (do_timeout) begin
				elapsed_q <= '0;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// burst walker and retired sequence number
	always_ff @(posedge clk) begin
		if (do_ack) begin
			cur_seq_q <= base_seq_q;
		end else if (do_timeout) begin
			cur_seq_q <= base_seq_q;
			rd_slot_q <= base_slot_q;
			left_q    <= cnt_q;
		end else if (do_step) begin
			cur_seq_q <= cur_seq_q + 32'd1;
			rd_slot_q <= slot_inc(rd_slot_q);
			left_q    <= left_q - 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (res_pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/go_back_n_sender_window_core.sv
// Go-back-n sender window: a send, ack and tick queue in, a result queue out.
// Sends, refused sends, ignored acks and ticks are all handled in the idle state;
// an ack that retires the base waits in ST_ACK_OUT for the ring's registered read,
// and a timeout burst runs ST_BURST_RD then ST_BURST_OUT per outstanding entry, read
// one by one from the payload ring into the single result register. A two-word
// command queue lets input words be taken while a result waits to be popped.
// The ring needs no clearing pass: only entries written by a send are ever read.
// Depends on gbns_pkg, gbns_front, gbns_back and gbns_ram.
`default_nettype none

module go_back_n_sender_window_core #(
	parameter int RING_DEPTH    = 64,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input queue
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  mode,
	input  wire logic [31:0] payload,
	input  wire logic [31:0] ack_seq,
	input  wire logic        ack_intact,
	// result queue
	output logic             empty,
	input  wire logic        pop,
	output logic [2:0]       kind,
	output logic [31:0]      seq_out,
	output logic [31:0]      payload_out,
	output logic             last,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [6:0]         window_size_q;
	logic [15:0]        timeout_ticks_q;
	logic [31:0]        first_seq_q;
	logic               cfg_wr;
	logic [1:0]         cfg_idx;
	logic               restart;
	logic               q_vld, q_deq, res_vld;
	gbns_pkg::item_t    q_item;
	gbns_pkg::result_t  res;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[3:2];
	assign restart = cfg_wr && (cfg_idx == gbns_pkg::REG_FIRST_SEQ);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q   <= gbns_pkg::WINDOW_SIZE_RST;
			timeout_ticks_q <= gbns_pkg::TIMEOUT_TICKS_RST;
			first_seq_q     <= gbns_pkg::FIRST_SEQ_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				gbns_pkg::REG_WINDOW_SIZE:   window_size_q   <= pwdata[6:0];
				gbns_pkg::REG_TIMEOUT_TICKS: timeout_ticks_q <= pwdata[15:0];
				gbns_pkg::REG_FIRST_SEQ:     first_seq_q     <= pwdata;
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (cfg_idx)
			gbns_pkg::REG_WINDOW_SIZE:   prdata = 32'(window_size_q);
			gbns_pkg::REG_TIMEOUT_TICKS: prdata = 32'(timeout_ticks_q);
			gbns_pkg::REG_FIRST_SEQ:     prdata = first_seq_q;
			default:                     prdata = 32'd0;
		endcase
	end

	gbns_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.mode       (mode),
		.payload    (payload),
		.ack_seq    (ack_seq),
		.ack_intact (ack_intact),
		.q_vld      (q_vld),
		.q_item     (q_item),
		.q_deq      (q_deq)
	);

	gbns_back #(
		.RING_DEPTH    (RING_DEPTH),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.restart       (restart),
		.restart_seq   (pwdata),
		.window_size   (window_size_q),
		.timeout_ticks (timeout_ticks_q),
		.q_vld         (q_vld),
		.q_item        (q_item),
		.q_deq         (q_deq),
		.res_vld       (res_vld),
		.res           (res),
		.res_pop       (pop)
	);

	assign empty       = !res_vld;
	assign kind        = res.kind;
	assign seq_out     = res.seq;
	assign payload_out = res.payload;
	assign last        = res.last;

	// a shown word always carries a defined kind
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (kind <= 3'(gbns_pkg::KIND_FULL)))
		else $error("result word with undefined kind");

	// only resend bursts produce more than one word per command
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (kind != 3'(gbns_pkg::KIND_RETX))) |-> last)
		else $error("single-word result without last");

	// an ignored ack reports no descriptor
	a_ign_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (kind == 3'(gbns_pkg::KIND_IGN))) |-> (payload_out == 32'd0))
		else $error("ignored ack carries a descriptor");

endmodule

`default_nettype wire
